// ----- rtl/lhp_pkg.sv -----
// Link header parser package: link, verdict and parse-phase codes, ethertypes,
// and the fixed-width parse state handed from the parser to the verdict logic.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lhp_pkg;

  localparam int unsigned LengthBitsDefault = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_LINK_TYPE   = 2'd0;
  localparam logic [1:0] CFG_FAMILY_IPV4 = 2'd1;
  localparam logic [1:0] CFG_FAMILY_IPV6 = 2'd2;

  localparam logic [2:0] LinkTypeReset   = 3'd2;
  localparam logic [7:0] FamilyIpv4Reset = 8'd2;
  localparam logic [7:0] FamilyIpv6Reset = 8'd10;

  typedef enum logic [2:0] {
    LINK_NULL   = 3'd0,
    LINK_RAW    = 3'd1,
    LINK_ETH    = 3'd2,
    LINK_PPP    = 3'd3,
    LINK_COOKED = 3'd4
  } lhp_link_e;

  typedef enum logic [1:0] {
    VERDICT_DELIVER     = 2'd0,
    VERDICT_SHORT       = 2'd1,
    VERDICT_UNSUPPORTED = 2'd2,
    VERDICT_MPLS_OVERRUN = 2'd3
  } lhp_verdict_e;

  typedef enum logic [1:0] {
    PH_HEADER      = 2'd0,
    PH_MPLS        = 2'd1,
    PH_MPLS_BOTTOM = 2'd2,
    PH_BODY        = 2'd3
  } lhp_phase_e;

  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
  localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
  localparam logic [15:0] ETYPE_QINQ  = 16'h9100;
  localparam logic [15:0] ETYPE_8021AD = 16'h88A8;
  localparam logic [15:0] ETYPE_MPLS  = 16'h8847;

  typedef struct packed {
    logic [15:0] type_shift;
    lhp_phase_e  phase;
    logic [7:0]  first_family;
  } lhp_state_t;

  function automatic logic is_tag(input logic [15:0] t);
    return (t == ETYPE_VLAN) || (t == ETYPE_QINQ) || (t == ETYPE_8021AD);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lhp_parse.sv -----
// Link header parser: per-word header state machine and byte counter.
// Depends on lhp_pkg. Exposes the post-update state for the verdict logic.
`timescale 1ns / 1ps
`default_nettype none

module lhp_parse import lhp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   fire_i,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   last_byte_i,
  input  wire logic [2:0]             link_type_i,
  output logic      [LENGTH_BITS-1:0] count_o,
  output logic      [LENGTH_BITS-1:0] type_pos_o,
  output logic      [LENGTH_BITS-1:0] header_end_o,
  output lhp_state_t                  state_o
);

  localparam int unsigned LB = LENGTH_BITS;
  localparam logic [LB-1:0] CountMax = {LB{1'b1}};

  logic [LB-1:0] idx_q, idx_d;
  logic [LB-1:0] tp_q, tp_d;
  logic [LB-1:0] he_q, he_d;
  lhp_state_t    st_q, st_d;

  logic [LB:0]   pos;
  logic [LB+1:0] he_w;
  logic [LB+1:0] idx_w;

  always_comb begin
    pos   = (LB+1)'(tp_q) + (LB+1)'(12);
    he_w  = (LB+2)'(he_q);
    idx_w = (LB+2)'(idx_q);
    idx_d = idx_q;
    tp_d  = tp_q;
    he_d  = he_q;
    st_d  = st_q;
    if (idx_q != CountMax) begin
      idx_d = idx_q + LB'(1);
      if (idx_q == '0) st_d.first_family = data_byte_i;
      if (link_type_i == LINK_ETH && st_q.phase == PH_HEADER) begin
        if ((LB+1)'(idx_q) == pos) begin
          st_d.type_shift = {8'h00, data_byte_i};
        end else if ((LB+1)'(idx_q) == pos + (LB+1)'(1)) begin
          st_d.type_shift = {st_q.type_shift[7:0], data_byte_i};
          if (is_tag({st_q.type_shift[7:0], data_byte_i})) tp_d = tp_q + LB'(4);
          else st_d.phase = PH_BODY;
        end
      end else if (link_type_i == LINK_COOKED) begin
        if (st_q.phase == PH_HEADER) begin
          if (idx_q == LB'(14)) begin
            st_d.type_shift = {8'h00, data_byte_i};
          end else if (idx_q == LB'(15)) begin
            st_d.type_shift = {st_q.type_shift[7:0], data_byte_i};
            he_d = LB'(16);
            st_d.phase = ({st_q.type_shift[7:0], data_byte_i} == ETYPE_MPLS) ?
                         PH_MPLS : PH_BODY;
          end
        end else if (st_q.phase == PH_MPLS || st_q.phase == PH_MPLS_BOTTOM) begin
          if (idx_w == he_w + (LB+2)'(2)) begin
            st_d.phase = data_byte_i[0] ? PH_MPLS_BOTTOM : PH_MPLS;
          end else if (idx_w == he_w + (LB+2)'(3)) begin
            he_d = he_q + LB'(4);
            if (st_q.phase == PH_MPLS_BOTTOM) st_d.phase = PH_BODY;
          end
        end
      end
    end
  end

  // The verdict logic sees the state after this word
  assign count_o      = idx_d;
  assign type_pos_o   = tp_d;
  assign header_end_o = he_d;
  assign state_o      = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      tp_q  <= '0;
      he_q  <= '0;
      st_q  <= '{type_shift: 16'h0000, phase: PH_HEADER, first_family: 8'h00};
    end else if (fire_i) begin
      if (last_byte_i) begin
        idx_q <= '0;
        tp_q  <= '0;
        he_q  <= '0;
        st_q  <= '{type_shift: 16'h0000, phase: PH_HEADER, first_family: 8'h00};
      end else begin
        idx_q <= idx_d;
        tp_q  <= tp_d;
        he_q  <= he_d;
        st_q  <= st_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lhp_verdict.sv -----
// Link header parser: end-of-frame verdict, payload offset/length and protocol.
// Depends on lhp_pkg. Purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module lhp_verdict import lhp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  wire logic [2:0]             link_type_i,
  input  wire logic [7:0]             family_ipv4_i,
  input  wire logic [7:0]             family_ipv6_i,
  input  wire logic [LENGTH_BITS-1:0] count_i,
  input  wire logic [LENGTH_BITS-1:0] type_pos_i,
  input  wire logic [LENGTH_BITS-1:0] header_end_i,
  input  wire lhp_state_t             state_i,
  output lhp_verdict_e                verdict_o,
  output logic [15:0]                 payload_offset_o,
  output logic [15:0]                 payload_length_o,
  output logic [15:0]                 link_protocol_o
);

  localparam int unsigned LB = LENGTH_BITS;

  logic [LB:0]  n_w;
  logic [LB:0]  eth_off;
  logic [LB:0]  he_w;
  logic [LB:0]  off_w;
  logic [LB:0]  len_w;
  logic [15:0]  proto;
  lhp_verdict_e v;

  always_comb begin
    n_w     = (LB+1)'(count_i);
    eth_off = (LB+1)'(type_pos_i) + (LB+1)'(14);
    he_w    = (LB+1)'(header_end_i);
    v       = VERDICT_SHORT;
    off_w   = '0;
    len_w   = '0;
    proto   = '0;
    unique case (link_type_i)
      LINK_NULL: begin
        if (n_w >= (LB+1)'(4)) begin
          off_w = (LB+1)'(4);
          len_w = n_w - (LB+1)'(4);
          proto = {8'h00, state_i.first_family};
          v = (state_i.first_family == family_ipv4_i ||
               state_i.first_family == family_ipv6_i) ? VERDICT_DELIVER
                                                      : VERDICT_UNSUPPORTED;
        end
      end
      LINK_RAW: begin
        v     = VERDICT_DELIVER;
        len_w = n_w;
      end
      LINK_ETH: begin
        if (state_i.phase == PH_BODY && eth_off <= n_w) begin
          off_w = eth_off;
          len_w = n_w - eth_off;
          proto = state_i.type_shift;
          v = (state_i.type_shift == ETYPE_IPV4 || state_i.type_shift == ETYPE_IPV6) ?
              VERDICT_DELIVER : VERDICT_UNSUPPORTED;
        end
      end
      LINK_PPP: begin
        if (n_w >= (LB+1)'(4)) begin
          v     = VERDICT_DELIVER;
          off_w = (LB+1)'(4);
          len_w = n_w - (LB+1)'(4);
        end
      end
      LINK_COOKED: begin
        if (n_w < (LB+1)'(16)) begin
          v = VERDICT_SHORT;
        end else if (state_i.phase == PH_MPLS || state_i.phase == PH_MPLS_BOTTOM) begin
          v     = VERDICT_MPLS_OVERRUN;
          proto = ETYPE_MPLS;
        end else if (state_i.phase == PH_BODY && he_w <= n_w &&
                     he_w >= (LB+1)'(16)) begin
          v     = VERDICT_DELIVER;
          off_w = he_w;
          len_w = n_w - he_w;
          proto = state_i.type_shift;
        end
      end
      default: v = VERDICT_UNSUPPORTED;
    endcase
  end

  assign verdict_o        = v;
  assign payload_offset_o = 16'(off_w);
  assign payload_length_o = 16'(len_w);
  assign link_protocol_o  = proto;

endmodule

`default_nettype wire

// ----- rtl/link_header_parser_unit.sv -----
// Link header parser top level: configuration registers, input word register,
// result register. Depends on lhp_pkg, lhp_parse and lhp_verdict.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  - Input channel: one captured frame byte per word on data_byte_i, with
//    last_byte_i set on the final byte. A word is taken when in_valid_i is
//    high and in_stall_o is low.
//  - Output channel: one result word per frame (verdict, payload offset,
//    payload length, protocol), taken when out_valid_o is high and
//    out_stall_i is low.
//  - Config channel: cfg_index_i selects link_type (0), family_ipv4 (1) or
//    family_ipv6 (2); other indexes are ignored. cfg_ready_o is always high.
//    Write only while no frame is in flight.
//  - Throughput: one byte per cycle while out_stall_i holds no result. Each
//    byte needs only compares against the held tag/label positions, done
//    between the input word register and the result register.
//  - Result path: the last byte is taken into the input register; its
//    result word is then registered in the result register.
//  - Stall: a valid result word holds while out_stall_i is high; the input
//    register keeps accepting until it holds a word that cannot advance.
//  - Reset: link type Ethernet, families 2 and 10, frame state cleared.
module link_header_parser_unit import lhp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // input bytes
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       verdict_o,
  output logic [15:0]      payload_offset_o,
  output logic [15:0]      payload_length_o,
  output logic [15:0]      link_protocol_o
);

  // Configuration registers
  logic [2:0] link_type_q;
  logic [7:0] fam4_q, fam6_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_type_q <= LinkTypeReset;
      fam4_q      <= FamilyIpv4Reset;
      fam6_q      <= FamilyIpv6Reset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LINK_TYPE:   link_type_q <= cfg_data_i[2:0];
        CFG_FAMILY_IPV4: fam4_q      <= cfg_data_i;
        CFG_FAMILY_IPV6: fam6_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: the result register advances when empty or drained
  logic in_valid_q, in_last_q;
  logic [7:0] in_byte_q;
  logic out_valid_q;
  logic advance, fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // Header walk
  logic [LENGTH_BITS-1:0] count, type_pos, header_end;
  lhp_state_t             pstate;

  lhp_parse #(.LENGTH_BITS(LENGTH_BITS)) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (in_byte_q),
    .last_byte_i  (in_last_q),
    .link_type_i  (link_type_q),
    .count_o      (count),
    .type_pos_o   (type_pos),
    .header_end_o (header_end),
    .state_o      (pstate)
  );

  // End-of-frame decision on the state after the last byte
  lhp_verdict_e v_d;
  logic [15:0]  off_d, len_d, proto_d;

  lhp_verdict #(.LENGTH_BITS(LENGTH_BITS)) u_verdict (
    .link_type_i      (link_type_q),
    .family_ipv4_i    (fam4_q),
    .family_ipv6_i    (fam6_q),
    .count_i          (count),
    .type_pos_i       (type_pos),
    .header_end_i     (header_end),
    .state_i          (pstate),
    .verdict_o        (v_d),
    .payload_offset_o (off_d),
    .payload_length_o (len_d),
    .link_protocol_o  (proto_d)
  );

  // Result register
  logic [1:0]  verdict_q;
  logic [15:0] off_q, len_q, proto_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) begin
      verdict_q <= v_d;
      off_q     <= off_d;
      len_q     <= len_d;
      proto_q   <= proto_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign payload_offset_o = off_q;
  assign payload_length_o = len_q;
  assign link_protocol_o  = proto_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for link_header_parser_unit: drives captured frames a
// byte per word under all link types and compares every result word against
// an in-bench header tracker. Depends on lhp_pkg and the parser RTL.
`timescale 1ns / 1ps

module testbench;
  import lhp_pkg::*;

  localparam int unsigned FrameCountMax = (1 << LengthBitsDefault) - 1;
  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned MaxReports    = 10;
  // Not a real register; the block must ignore writes to it.
  localparam logic [1:0]  CFG_UNUSED    = 2'd3;
  // A well-known ethertype that the parser does not deliver.
  localparam logic [15:0] ETYPE_ARP     = 16'h0806;

  typedef struct packed {
    lhp_verdict_e verdict;
    logic [15:0]  offset;
    logic [15:0]  length;
    logic [15:0]  proto;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  verdict_o;
  logic [15:0] payload_offset_o;
  logic [15:0] payload_length_o;
  logic [15:0] link_protocol_o;

  link_header_parser_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .verdict_o        (verdict_o),
    .payload_offset_o (payload_offset_o),
    .payload_length_o (payload_length_o),
    .link_protocol_o  (link_protocol_o)
  );

  always #4 clk_i = ~clk_i;

  // Register shadows, written on each accepted config write.
  logic [2:0] cfg_link = LinkTypeReset;
  logic [7:0] cfg_fam4 = FamilyIpv4Reset;
  logic [7:0] cfg_fam6 = FamilyIpv6Reset;

  // Per-frame header tracking state; cleared after every last byte.
  int unsigned byte_count;
  int unsigned tag_skip;
  int unsigned hdr_end;
  logic [15:0] type_acc;
  logic [7:0]  first_fam;
  lhp_phase_e  hdr_phase;

  frame_result_t pending_verdicts[$];
  logic [7:0]    frame_buf[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned results_checked;
  int unsigned config_writes;
  int unsigned mismatches;
  int unsigned cycle_count;

  function automatic void clear_frame_state();
    byte_count = 0;
    tag_skip   = 0;
    hdr_end    = 0;
    type_acc   = '0;
    first_fam  = '0;
    hdr_phase  = PH_HEADER;
  endfunction

  // Advance the header tracker by one byte at position idx.
  function automatic void track_header_byte(input int unsigned idx, input logic [7:0] b);
    int unsigned type_at;
    type_at = 12 + tag_skip;
    if (idx == 0) first_fam = b;
    if (cfg_link == LINK_ETH && hdr_phase == PH_HEADER) begin
      if (idx == type_at) begin
        type_acc = {8'd0, b};
      end else if (idx == type_at + 1) begin
        type_acc = {type_acc[7:0], b};
        // any tag pushes the type field four bytes further out
        if (type_acc == ETYPE_VLAN || type_acc == ETYPE_QINQ || type_acc == ETYPE_8021AD)
          tag_skip += 4;
        else
          hdr_phase = PH_BODY;
      end
    end else if (cfg_link == LINK_COOKED) begin
      if (hdr_phase == PH_HEADER) begin
        if (idx == 14) begin
          type_acc = {8'd0, b};
        end else if (idx == 15) begin
          type_acc = {type_acc[7:0], b};
          hdr_end  = 16;
          if (type_acc == ETYPE_MPLS) hdr_phase = PH_MPLS;
          else hdr_phase = PH_BODY;
        end
      end else if (hdr_phase == PH_MPLS || hdr_phase == PH_MPLS_BOTTOM) begin
        // bottom-of-stack flag sits in bit 0 of the third label byte
        if (idx == hdr_end + 2) begin
          if (b[0]) hdr_phase = PH_MPLS_BOTTOM;
          else hdr_phase = PH_MPLS;
        end else if (idx == hdr_end + 3) begin
          hdr_end += 4;
          if (hdr_phase == PH_MPLS_BOTTOM) hdr_phase = PH_BODY;
        end
      end
    end
  endfunction

  // Result word for a frame of n captured bytes.
  function automatic frame_result_t frame_verdict(input int unsigned n);
    frame_result_t r;
    int unsigned   start;
    r.verdict = VERDICT_SHORT;
    r.offset  = '0;
    r.length  = '0;
    r.proto   = '0;
    start     = 14 + tag_skip;
    case (cfg_link)
      LINK_NULL: begin
        if (n >= 4) begin
          r.offset = 16'd4;
          r.length = 16'(n - 4);
          r.proto  = {8'd0, first_fam};
          if (first_fam == cfg_fam4 || first_fam == cfg_fam6) r.verdict = VERDICT_DELIVER;
          else r.verdict = VERDICT_UNSUPPORTED;
        end
      end
      LINK_RAW: begin
        r.verdict = VERDICT_DELIVER;
        r.length  = 16'(n);
      end
      LINK_ETH: begin
        if (hdr_phase == PH_BODY && start <= n) begin
          r.offset = 16'(start);
          r.length = 16'(n - start);
          r.proto  = type_acc;
          if (type_acc == ETYPE_IPV4 || type_acc == ETYPE_IPV6) r.verdict = VERDICT_DELIVER;
          else r.verdict = VERDICT_UNSUPPORTED;
        end
      end
      LINK_PPP: begin
        if (n >= 4) begin
          r.verdict = VERDICT_DELIVER;
          r.offset  = 16'd4;
          r.length  = 16'(n - 4);
        end
      end
      LINK_COOKED: begin
        if (n < 16) begin
          r.verdict = VERDICT_SHORT;
        end else if (hdr_phase == PH_MPLS || hdr_phase == PH_MPLS_BOTTOM) begin
          r.verdict = VERDICT_MPLS_OVERRUN;
          r.proto   = ETYPE_MPLS;
        end else if (hdr_phase == PH_BODY && hdr_end <= n && hdr_end >= 16) begin
          r.verdict = VERDICT_DELIVER;
          r.offset  = 16'(hdr_end);
          r.length  = 16'(n - hdr_end);
          r.proto   = type_acc;
        end
      end
      default: r.verdict = VERDICT_UNSUPPORTED;
    endcase
    return r;
  endfunction

  // Called on every accepted input word.
  function automatic void take_byte(input logic [7:0] b, input logic last);
    // count saturates; bytes beyond it are not parsed
    if (byte_count < FrameCountMax) begin
      track_header_byte(byte_count, b);
      byte_count++;
    end
    if (last) begin
      pending_verdicts.push_back(frame_verdict(byte_count));
      clear_frame_state();
    end
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("MISMATCH: %s", msg);
  endfunction

  // Result checker: every accepted result word against the oldest expectation.
  frame_result_t seen_result;
  frame_result_t want_result;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_result.verdict = lhp_verdict_e'(verdict_o);
      seen_result.offset  = payload_offset_o;
      seen_result.length  = payload_length_o;
      seen_result.proto   = link_protocol_o;
      if (pending_verdicts.size() == 0) begin
        note_failure($sformatf("unexpected result: verdict %0d off %0d len %0d proto %h",
                               verdict_o, payload_offset_o, payload_length_o,
                               link_protocol_o));
      end else begin
        want_result = pending_verdicts.pop_front();
        if (seen_result.verdict !== want_result.verdict ||
            seen_result.offset !== want_result.offset ||
            seen_result.length !== want_result.length ||
            seen_result.proto !== want_result.proto)
          note_failure($sformatf(
            "result %0d: expected verdict %0d off %0d len %0d proto %h, got %0d %0d %0d %h",
            results_checked, want_result.verdict, want_result.offset, want_result.length,
            want_result.proto, seen_result.verdict, seen_result.offset,
            seen_result.length, seen_result.proto));
      end
      results_checked++;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) out_stall_i = ($urandom_range(99) < recv_idle_pct);

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_verdicts.size());
      $display("link_header_parser_unit verification failed");
      $finish;
    end
  end

  // Sends one word; entered and left just after a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    data_byte_i = b;
    last_byte_i = last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    take_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    int unsigned i;
    for (i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frame_buf.delete();
    frames_sent++;
  endtask

  // Drain all results, then let the two-stage pipe settle.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_LINK_TYPE:   cfg_link = val[2:0];
      CFG_FAMILY_IPV4: cfg_fam4 = val;
      CFG_FAMILY_IPV6: cfg_fam6 = val;
      default: ;
    endcase
    config_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) frame_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic push_fill(input logic [7:0] v, input int unsigned n);
    repeat (n) frame_buf.push_back(v);
  endtask

  task automatic push_word16(input logic [15:0] w);
    frame_buf.push_back(w[15:8]);
    frame_buf.push_back(w[7:0]);
  endtask

  // tag type plus two TCI bytes
  task automatic push_tag(input logic [15:0] tpid);
    push_word16(tpid);
    push_random(2);
  endtask

  task automatic push_label(input logic bottom);
    push_random(2);
    frame_buf.push_back({7'($urandom_range(127)), bottom});
    push_random(1);
  endtask

  // Mostly well-formed frames for the current link type, some cut short.
  task automatic build_random_frame();
    int unsigned n_tags;
    int unsigned n_labels;
    int unsigned keep;
    int unsigned i;
    logic        broken;
    logic [15:0] etype;
    case (cfg_link)
      LINK_NULL: begin
        case ($urandom_range(2))
          0: frame_buf.push_back(cfg_fam4);
          1: frame_buf.push_back(cfg_fam6);
          default: push_random(1);
        endcase
        push_random($urandom_range(30));
      end
      LINK_ETH: begin
        push_random(12);
        n_tags = $urandom_range(3);
        repeat (n_tags) begin
          case ($urandom_range(2))
            0: push_tag(ETYPE_VLAN);
            1: push_tag(ETYPE_QINQ);
            default: push_tag(ETYPE_8021AD);
          endcase
        end
        case ($urandom_range(9))
          0, 1, 2, 3: etype = ETYPE_IPV4;
          4, 5, 6: etype = ETYPE_IPV6;
          default: etype = 16'($urandom_range(16'hFFFF));
        endcase
        push_word16(etype);
        push_random($urandom_range(24));
      end
      LINK_COOKED: begin
        push_random(14);
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: etype = ETYPE_MPLS;
          6, 7: etype = ETYPE_IPV4;
          default: etype = 16'($urandom_range(16'hFFFF));
        endcase
        push_word16(etype);
        if (etype == ETYPE_MPLS) begin
          n_labels = $urandom_range(1, 4);
          broken   = ($urandom_range(9) == 0);  // stack never terminates
          for (i = 0; i < n_labels; i++) push_label(i == n_labels - 1 && !broken);
        end
        push_random($urandom_range(20));
      end
      default: push_random($urandom_range(1, 30));
    endcase
    if ($urandom_range(99) < 15) begin
      keep = $urandom_range(1, frame_buf.size());
      while (frame_buf.size() > keep) void'(frame_buf.pop_back());
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    // Ethernet with families 2 and 10 out of reset
    push_fill(8'hFF, 12);
    push_word16(ETYPE_IPV4);
    push_fill(8'h00, 4);
    send_frame();
    write_register(CFG_LINK_TYPE, 8'(LINK_NULL));
    frame_buf.push_back(FamilyIpv4Reset);
    push_random(3);
    send_frame();
    frame_buf.push_back(FamilyIpv6Reset);
    push_random(5);
    send_frame();
  endtask

  task automatic test_null_link();
    frame_buf.push_back(8'h55);  // unknown family
    push_random(6);
    send_frame();
    frame_buf.push_back(FamilyIpv4Reset);  // three bytes: short
    push_random(2);
    send_frame();
    write_register(CFG_FAMILY_IPV4, 8'h00);
    write_register(CFG_FAMILY_IPV6, 8'hFF);
    push_fill(8'h00, 4);
    send_frame();
    push_fill(8'hFF, 10);
    send_frame();
  endtask

  task automatic test_raw_and_ppp();
    write_register(CFG_LINK_TYPE, 8'(LINK_RAW));
    push_fill(8'hFF, 1);
    send_frame();
    push_random(5);
    send_frame();
    write_register(CFG_LINK_TYPE, 8'(LINK_PPP));
    push_random(3);
    send_frame();
    push_random(4);
    send_frame();
    push_random(10);
    send_frame();
  endtask

  task automatic test_ethernet_tags();
    write_register(CFG_LINK_TYPE, 8'(LINK_ETH));
    push_random(12);
    push_word16(ETYPE_IPV6);
    push_random(6);
    send_frame();
    push_random(12);
    push_tag(ETYPE_VLAN);
    push_word16(ETYPE_IPV4);
    push_random(3);
    send_frame();
    push_random(12);
    push_tag(ETYPE_QINQ);
    push_tag(ETYPE_VLAN);
    push_word16(ETYPE_IPV6);
    push_random(2);
    send_frame();
    push_random(12);  // 802.1ad, ends right after the type: empty payload
    push_tag(ETYPE_8021AD);
    push_word16(ETYPE_IPV4);
    send_frame();
    push_random(12);
    push_word16(ETYPE_ARP);
    push_random(4);
    send_frame();
    push_random(13);  // type field cut in half
    send_frame();
    push_random(12);  // inner type cut in half
    push_tag(ETYPE_VLAN);
    push_random(1);
    send_frame();
  endtask

  task automatic test_cooked_mpls();
    write_register(CFG_LINK_TYPE, 8'(LINK_COOKED));
    push_random(15);
    send_frame();
    push_random(14);
    push_word16(ETYPE_IPV4);
    send_frame();
    push_random(14);
    push_word16(ETYPE_MPLS);
    push_label(1'b1);
    push_random(8);
    send_frame();
    push_random(14);
    push_word16(ETYPE_MPLS);
    push_label(1'b0);
    push_label(1'b0);
    push_label(1'b1);
    push_random(4);
    send_frame();
    // stack without a bottom label runs off the end
    push_random(14);
    push_word16(ETYPE_MPLS);
    push_label(1'b0);
    push_random(3);
    send_frame();
    push_random(14);
    push_word16(ETYPE_MPLS);
    send_frame();
    push_random(14);
    push_word16(ETYPE_MPLS);
    push_random(2);
    send_frame();
  endtask

  task automatic test_reserved_link_types();
    int unsigned lt;
    for (lt = 5; lt <= 7; lt++) begin
      write_register(CFG_LINK_TYPE, {5'b11111, 3'(lt)});  // upper bits are don't-care
      push_random(6);
      send_frame();
    end
    write_register(CFG_UNUSED, 8'h01);
    push_random(3);
    send_frame();
  endtask

  task automatic test_random_traffic(input int unsigned sender_idle,
                                     input int unsigned receiver_idle,
                                     input int unsigned byte_budget);
    int unsigned first_byte;
    int unsigned first_result;
    logic [2:0]  lt;
    logic [7:0]  lt_word;
    logic [7:0]  fam;
    first_byte    = bytes_sent;
    first_result  = results_checked;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    while (bytes_sent - first_byte < byte_budget || results_checked - first_result < 20) begin
      if ($urandom_range(99) < 90) lt = 3'($urandom_range(4));
      else lt = 3'($urandom_range(5, 7));
      lt_word      = 8'($urandom_range(255));
      lt_word[2:0] = lt;
      write_register(CFG_LINK_TYPE, lt_word);
      fam = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) fam = $urandom_range(1) ? 8'hFF : 8'h00;
      write_register(CFG_FAMILY_IPV4, fam);
      fam = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) fam = $urandom_range(1) ? 8'hFF : 8'h00;
      write_register(CFG_FAMILY_IPV6, fam);
      repeat ($urandom_range(4, 10)) begin
        build_random_frame();
        send_frame();
      end
    end
  endtask

  initial begin
    clear_frame_state();
    send_idle_pct = 27;
    recv_idle_pct = 84;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_null_link();
    test_raw_and_ppp();
    test_ethernet_tags();
    test_cooked_mpls();
    test_reserved_link_types();
    test_random_traffic(27, 84, 240);
    test_random_traffic(84, 27, 240);
    test_random_traffic(0, 0, 240);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (pending_verdicts.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_verdicts.size()));
    $display("Covered %0d frames (%0d bytes) over link types 0-7, tag and MPLS stacks,",
             frames_sent, bytes_sent);
    $display("truncated frames and mixed stalls: %0d results, %0d register writes, %0d errors",
             results_checked, config_writes, mismatches);
    if (mismatches == 0) begin
      $display("link_header_parser_unit verification clean");
    end else begin
      $display("link_header_parser_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- link_header_parser_unit.f -----
rtl/lhp_pkg.sv
rtl/lhp_parse.sv
rtl/lhp_verdict.sv
rtl/link_header_parser_unit.sv
tb/testbench.sv
